@@ rtl/core/mwfr_pkg.sv @@
// Shared constants for the Maxwell f-wave split pipeline.
// Used by the top level, the fixed-point multiplier and the port checker.
package mwfr_pkg;

	// Default number format: signed Q16.16.
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Each input transaction produces one result per state component.
	localparam int              NUM_COMP  = 8;
	localparam int              COMP_W    = 3;
	localparam logic [COMP_W-1:0] LAST_COMP = 3'd7;

	// Sweep direction codes; the unused code three behaves as x.
	localparam logic [1:0] DIR_Y = 2'd1;
	localparam logic [1:0] DIR_Z = 2'd2;

	// Configuration register indexes.
	localparam int         CFG_IDX_W         = 2;
	localparam logic [1:0] CFG_LIGHT_SPEED   = 2'd0;
	localparam logic [1:0] CFG_INV_LIGHT     = 2'd1;
	localparam logic [1:0] CFG_MAG_CLEANING  = 2'd2;
	localparam logic [1:0] CFG_ELEC_CLEANING = 2'd3;

endpackage

@@ rtl/core/mwfr_fmul.sv @@
// Signed fixed-point multiply with round half away from zero and saturation.
// Purely combinational; depends on mwfr_pkg for default widths.
module mwfr_fmul
	import mwfr_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic signed [DATA_WIDTH-1:0] a,
	input  logic signed [DATA_WIDTH-1:0] b,
	output logic signed [DATA_WIDTH-1:0] y
);

	localparam int PW = 2 * DATA_WIDTH;
	localparam int SW = PW + 1;
	localparam int MW = SW - FRAC_BITS;
	localparam logic [SW-1:0] RND = SW'(1) << (FRAC_BITS - 1);
	localparam logic [MW-1:0] LIM = MW'(1) << (DATA_WIDTH - 1);
	localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic [DATA_WIDTH-1:0] mag_a;
	logic [DATA_WIDTH-1:0] mag_b;
	logic [PW-1:0]         prod;
	logic [SW-1:0]         rsum;
	logic [MW-1:0]         mag_m;
	logic                  negative;

	// Multiply magnitudes, then round by adding half an LSB before the shift.
	always_comb begin
		mag_a    = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
		mag_b    = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
		prod     = PW'(mag_a) * PW'(mag_b);
		rsum     = SW'(prod) + RND;
		mag_m    = rsum[SW-1:FRAC_BITS];
		negative = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
	end

	// Apply the sign and clamp to the signed range.
	always_comb begin
		if (!negative) begin
			y = (mag_m >= LIM) ? VMAX : mag_m[DATA_WIDTH-1:0];
		end else if (mag_m >= LIM) begin
			y = VMIN;
		end else begin
			y = ~mag_m[DATA_WIDTH-1:0] + 1'b1;
		end
	end

endmodule

@@ rtl/core/maxwell_fwave_riemann_split.sv @@
// An item passes through the stage 1 to stage 5 registers into the result buffer, and
// the single result port delivers its eight component results in order; five compute
// stages run behind it and take new items while it is still busy with an older one.
// Reset clears all valid bits and the output count and restores the registers
// to c = 1.0, 1/c = 1.0, gamma = 0, chi = 0. Depends on mwfr_pkg and mwfr_fmul.
module maxwell_fwave_riemann_split
	import mwfr_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration write channel.
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [DATA_WIDTH-2:0]        cfg_data,
	// Input channel.
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   direction,
	input  logic signed [DATA_WIDTH-1:0] jump_0,
	input  logic signed [DATA_WIDTH-1:0] jump_1,
	input  logic signed [DATA_WIDTH-1:0] jump_2,
	input  logic signed [DATA_WIDTH-1:0] jump_3,
	input  logic signed [DATA_WIDTH-1:0] jump_4,
	input  logic signed [DATA_WIDTH-1:0] jump_5,
	input  logic signed [DATA_WIDTH-1:0] jump_6,
	input  logic signed [DATA_WIDTH-1:0] jump_7,
	// Result channel.
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [COMP_W-1:0]            component,
	output logic signed [DATA_WIDTH-1:0] left_fluctuation,
	output logic signed [DATA_WIDTH-1:0] right_fluctuation,
	output logic                         last
);

	typedef logic signed [DATA_WIDTH-1:0] word_t;
	typedef logic [DATA_WIDTH-2:0]        ureg_t;

	localparam ureg_t CFG_ONE = ureg_t'(1) << FRAC_BITS;
	localparam word_t VMAX    = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam word_t VMIN    = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// Saturating negation.
	function automatic word_t fneg(input word_t x);
		return (x == VMIN) ? VMAX : word_t'(~x + 1'b1);
	endfunction

	// Floor of half the exact sum; cannot overflow.
	function automatic word_t fhalf(input word_t x, input word_t y);
		logic [DATA_WIDTH:0] s;
		s = {x[DATA_WIDTH-1], x} + {y[DATA_WIDTH-1], y};
		return s[DATA_WIDTH:1];
	endfunction

	// Configuration registers.
	ureg_t light_speed_q;
	ureg_t inv_light_q;
	ureg_t gamma_q;
	ureg_t chi_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_speed_q <= CFG_ONE;
			inv_light_q   <= CFG_ONE;
			gamma_q       <= '0;
			chi_q         <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LIGHT_SPEED:   light_speed_q <= cfg_data;
				CFG_INV_LIGHT:     inv_light_q   <= cfg_data;
				CFG_MAG_CLEANING:  gamma_q       <= cfg_data;
				CFG_ELEC_CLEANING: chi_q         <= cfg_data;
				default:           light_speed_q <= light_speed_q;
			endcase
		end
	end

	word_t c_w;
	word_t ic_w;
	word_t gamma_w;
	word_t chi_w;

	assign c_w     = {1'b0, light_speed_q};
	assign ic_w    = {1'b0, inv_light_q};
	assign gamma_w = {1'b0, gamma_q};
	assign chi_w   = {1'b0, chi_q};

	// Pipeline control: a stage loads when it is empty or its content moves on.
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic en1, en2, en3, en4, en5;
	logic buf_vld_q;
	logic [COMP_W-1:0] cnt_q;
	logic out_take, out_done, buf_free, buf_load;

	assign out_take = buf_vld_q && !out_stall;
	assign out_done = out_take && (cnt_q == LAST_COMP);
	assign buf_free = !buf_vld_q || out_done;
	assign buf_load = v5_s5 && buf_free;
	assign en5      = !v5_s5 || buf_free;
	assign en4      = !v4_s4 || en5;
	assign en3      = !v3_s3 || en4;
	assign en2      = !v2_s2 || en3;
	assign en1      = !v1_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= in_valid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
			if (en5) v5_s5 <= v4_s4;
		end
	end

	// Stage 1: permute E and B so the sweep axis comes first.
	// Roles: Ex, Ey, Ez, Bx, By, Bz, electric potential, magnetic potential.
	word_t role_in [NUM_COMP];
	word_t role_s1 [NUM_COMP];
	logic [1:0] dir_s1;

	always_comb begin
		case (direction)
			DIR_Y: begin
				role_in[0] = jump_1; role_in[1] = jump_2; role_in[2] = jump_0;
				role_in[3] = jump_4; role_in[4] = jump_5; role_in[5] = jump_3;
			end
			DIR_Z: begin
				role_in[0] = jump_2; role_in[1] = jump_0; role_in[2] = jump_1;
				role_in[3] = jump_5; role_in[4] = jump_3; role_in[5] = jump_4;
			end
			default: begin
				// Direction x, and the unused code that is treated as x.
				role_in[0] = jump_0; role_in[1] = jump_1; role_in[2] = jump_2;
				role_in[3] = jump_3; role_in[4] = jump_4; role_in[5] = jump_5;
			end
		endcase
		role_in[6] = jump_6;
		role_in[7] = jump_7;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			role_s1 <= role_in;
			dir_s1  <= direction;
		end
	end

	// Stage 2: scale electric jumps by 1/c, Bx by c, and form the cleaning speeds.
	word_t mul2_a [6];
	word_t mul2_b [6];
	word_t mul2_y [6];
	word_t e0_s2, e1_s2, e2_s2, b3_s2, cg_s2, ck_s2;
	word_t by_s2, bz_s2, p_s2, q_s2;
	logic [1:0] dir_s2;

	always_comb begin
		mul2_a[0] = role_s1[0]; mul2_b[0] = ic_w;
		mul2_a[1] = role_s1[1]; mul2_b[1] = ic_w;
		mul2_a[2] = role_s1[2]; mul2_b[2] = ic_w;
		mul2_a[3] = role_s1[3]; mul2_b[3] = c_w;
		mul2_a[4] = c_w;        mul2_b[4] = gamma_w;
		mul2_a[5] = c_w;        mul2_b[5] = chi_w;
	end

	for (genvar gi = 0; gi < 6; gi++) begin : g_mul2
		mwfr_fmul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul (
			.a(mul2_a[gi]),
			.b(mul2_b[gi]),
			.y(mul2_y[gi])
		);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			e0_s2  <= mul2_y[0];
			e1_s2  <= mul2_y[1];
			e2_s2  <= mul2_y[2];
			b3_s2  <= mul2_y[3];
			cg_s2  <= mul2_y[4];
			ck_s2  <= mul2_y[5];
			by_s2  <= role_s1[4];
			bz_s2  <= role_s1[5];
			p_s2   <= role_s1[6];
			q_s2   <= role_s1[7];
			dir_s2 <= dir_s1;
		end
	end

	// Stage 3: wave strengths a1..a8 as halved sums.
	word_t a_s3 [NUM_COMP];
	word_t cg_s3, ck_s3;
	logic [1:0] dir_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			a_s3[0] <= fhalf(e1_s2, bz_s2);
			a_s3[1] <= fhalf(fneg(e2_s2), by_s2);
			a_s3[2] <= fhalf(fneg(e1_s2), bz_s2);
			a_s3[3] <= fhalf(e2_s2, by_s2);
			a_s3[4] <= fhalf(b3_s2, q_s2);
			a_s3[5] <= fhalf(fneg(b3_s2), q_s2);
			a_s3[6] <= fhalf(e0_s2, p_s2);
			a_s3[7] <= fhalf(fneg(e0_s2), p_s2);
			cg_s3   <= cg_s2;
			ck_s3   <= ck_s2;
			dir_s3  <= dir_s2;
		end
	end

	// Stage 4: first speed products of each wave.
	word_t mul4_a [NUM_COMP];
	word_t mul4_b [NUM_COMP];
	word_t mul4_y [NUM_COMP];
	word_t m_s4 [NUM_COMP];
	word_t a_s4 [4];
	word_t cg_s4, ck_s4;
	logic [1:0] dir_s4;

	always_comb begin
		for (int k = 0; k < NUM_COMP; k++) begin
			mul4_a[k] = a_s3[k];
			mul4_b[k] = c_w;
		end
		// Magnetic cleaning waves are divided by c.
		mul4_b[4] = ic_w;
		mul4_b[5] = ic_w;
	end

	for (genvar gi = 0; gi < NUM_COMP; gi++) begin : g_mul4
		mwfr_fmul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul (
			.a(mul4_a[gi]),
			.b(mul4_b[gi]),
			.y(mul4_y[gi])
		);
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			m_s4   <= mul4_y;
			a_s4[0] <= a_s3[4];
			a_s4[1] <= a_s3[5];
			a_s4[2] <= a_s3[6];
			a_s4[3] <= a_s3[7];
			cg_s4  <= cg_s3;
			ck_s4  <= ck_s3;
			dir_s4 <= dir_s3;
		end
	end

	// Stage 5: second speed products and the signs of the left and right sums.
	word_t mul5_a [12];
	word_t mul5_b [12];
	word_t mul5_y [12];
	word_t rt_role [NUM_COMP];
	word_t lf_role [NUM_COMP];
	word_t rt_s5 [NUM_COMP];
	word_t lf_s5 [NUM_COMP];
	logic [1:0] dir_s5;

	always_comb begin
		mul5_a[0]  = c_w;   mul5_b[0]  = m_s4[0];
		mul5_a[1]  = c_w;   mul5_b[1]  = m_s4[1];
		mul5_a[2]  = cg_s4; mul5_b[2]  = m_s4[4];
		mul5_a[3]  = cg_s4; mul5_b[3]  = a_s4[0];
		mul5_a[4]  = ck_s4; mul5_b[4]  = m_s4[6];
		mul5_a[5]  = ck_s4; mul5_b[5]  = a_s4[2];
		mul5_a[6]  = c_w;   mul5_b[6]  = m_s4[2];
		mul5_a[7]  = c_w;   mul5_b[7]  = m_s4[3];
		mul5_a[8]  = cg_s4; mul5_b[8]  = m_s4[5];
		mul5_a[9]  = cg_s4; mul5_b[9]  = a_s4[1];
		mul5_a[10] = ck_s4; mul5_b[10] = m_s4[7];
		mul5_a[11] = ck_s4; mul5_b[11] = a_s4[3];
	end

	for (genvar gi = 0; gi < 12; gi++) begin : g_mul5
		mwfr_fmul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul (
			.a(mul5_a[gi]),
			.b(mul5_b[gi]),
			.y(mul5_y[gi])
		);
	end

	always_comb begin
		// Right-going sums, in role order.
		rt_role[0] = mul5_y[4];
		rt_role[1] = mul5_y[0];
		rt_role[2] = fneg(mul5_y[1]);
		rt_role[3] = mul5_y[2];
		rt_role[4] = m_s4[1];
		rt_role[5] = m_s4[0];
		rt_role[6] = mul5_y[5];
		rt_role[7] = mul5_y[3];
		// Left-going sums, in role order.
		lf_role[0] = mul5_y[10];
		lf_role[1] = mul5_y[6];
		lf_role[2] = fneg(mul5_y[7]);
		lf_role[3] = mul5_y[8];
		lf_role[4] = fneg(m_s4[3]);
		lf_role[5] = fneg(m_s4[2]);
		lf_role[6] = fneg(mul5_y[11]);
		lf_role[7] = fneg(mul5_y[9]);
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			rt_s5  <= rt_role;
			lf_s5  <= lf_role;
			dir_s5 <= dir_s4;
		end
	end

	// Undo the direction permutation on the way into the result buffer.
	word_t rt_comp [NUM_COMP];
	word_t lf_comp [NUM_COMP];

	always_comb begin
		rt_comp = rt_s5;
		lf_comp = lf_s5;
		case (dir_s5)
			DIR_Y: begin
				rt_comp[0] = rt_s5[2]; rt_comp[1] = rt_s5[0]; rt_comp[2] = rt_s5[1];
				rt_comp[3] = rt_s5[5]; rt_comp[4] = rt_s5[3]; rt_comp[5] = rt_s5[4];
				lf_comp[0] = lf_s5[2]; lf_comp[1] = lf_s5[0]; lf_comp[2] = lf_s5[1];
				lf_comp[3] = lf_s5[5]; lf_comp[4] = lf_s5[3]; lf_comp[5] = lf_s5[4];
			end
			DIR_Z: begin
				rt_comp[0] = rt_s5[1]; rt_comp[1] = rt_s5[2]; rt_comp[2] = rt_s5[0];
				rt_comp[3] = rt_s5[4]; rt_comp[4] = rt_s5[5]; rt_comp[5] = rt_s5[3];
				lf_comp[0] = lf_s5[1]; lf_comp[1] = lf_s5[2]; lf_comp[2] = lf_s5[0];
				lf_comp[3] = lf_s5[4]; lf_comp[4] = lf_s5[5]; lf_comp[5] = lf_s5[3];
			end
			default: begin
				rt_comp = rt_s5;
				lf_comp = lf_s5;
			end
		endcase
	end

	// Result buffer: holds one item and hands out its components in order.
	word_t buf_rt_q [NUM_COMP];
	word_t buf_lf_q [NUM_COMP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_vld_q <= 1'b0;
			cnt_q     <= '0;
		end else if (buf_load) begin
			buf_vld_q <= 1'b1;
			cnt_q     <= '0;
		end else if (out_done) begin
			buf_vld_q <= 1'b0;
		end else if (out_take) begin
			cnt_q <= COMP_W'(cnt_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (buf_load) begin
			buf_rt_q <= rt_comp;
			buf_lf_q <= lf_comp;
		end
	end

	assign out_valid         = buf_vld_q;
	assign component         = cnt_q;
	assign left_fluctuation  = buf_lf_q[cnt_q];
	assign right_fluctuation = buf_rt_q[cnt_q];
	assign last              = (cnt_q == LAST_COMP);

endmodule

@@ rtl/core/mwfr_checker.sv @@
// Port-level checks on the result channel of the f-wave split block.
// Depends on mwfr_pkg; bound to maxwell_fwave_riemann_split below.
module mwfr_checker
	import mwfr_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [COMP_W-1:0]            component,
	input logic signed [DATA_WIDTH-1:0] left_fluctuation,
	input logic signed [DATA_WIDTH-1:0] right_fluctuation,
	input logic                         last
);

	// A stalled result holds still.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(component) &&
			$stable(left_fluctuation) && $stable(right_fluctuation))
		else $error("stalled result changed");

	// The last flag marks exactly the final component.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (component == LAST_COMP)))
		else $error("last flag does not match component");

	// Components of one item follow one another without a gap.
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=>
			out_valid && (component == COMP_W'($past(component) + 1'b1)))
		else $error("component sequence broken");

	// A new item always starts at component zero.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid || (component == '0))
		else $error("item did not start at component zero");

endmodule

bind maxwell_fwave_riemann_split mwfr_checker #(.DATA_WIDTH(DATA_WIDTH)) u_mwfr_checker (.*);

@@ tb/maxwell_fwave_riemann_split_tb.sv @@
// Self-checking testbench for maxwell_fwave_riemann_split: a directed table, then random
// register phases, with every component result checked against hand-written values or a
// fixed-point predictor. Needs mwfr_pkg and the split RTL, and no files or arguments.
module maxwell_fwave_riemann_split_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mwfr_pkg::*;

	localparam int DW = DATA_WIDTH_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam longint Q_MAX = (longint'(1) << (DW - 1)) - 1;
	localparam longint Q_MIN = -Q_MAX - 1;
	localparam logic signed [DW-1:0] ONE = 1 <<< FB;
	localparam logic signed [DW-1:0] TWO = ONE <<< 1;
	localparam logic signed [DW-1:0] TOP = DW'(Q_MAX);
	localparam logic signed [DW-1:0] BOTTOM = DW'(Q_MIN);
	localparam logic [DW-2:0] SET_MAX = '1;
	localparam logic [DW-2:0] SET_LSB = (DW-1)'(1);
	localparam logic [DW-2:0] SET_ONE = SET_LSB << FB;

	// Direction codes the package leaves implicit.
	localparam logic [1:0] DIR_X = 2'd0;
	localparam logic [1:0] DIR_SPARE = 2'd3;

	// Directed rows either carry a hand-written expectation or go to the predictor.
	localparam int NO_KNOWN = -1;
	localparam int KNOWN_ZERO = 0;
	localparam int KNOWN_EY_X = 1;
	localparam int KNOWN_EZ_Z = 2;
	localparam int NUM_KNOWN = 3;

	localparam int NUM_DIRECTED = 17;
	localparam int NUM_PHASES = 8;
	localparam int LONG_HOLD = 60;
	localparam int SETTLE_CYCLES = 20;
	localparam int TIMEOUT_NS = 500_000;

	typedef struct {
		logic [1:0] dir;
		logic signed [DW-1:0] jump [NUM_COMP];
		int known;
	} interface_jump_t;

	typedef struct {
		logic [COMP_W-1:0] comp;
		logic signed [DW-1:0] left_sum;
		logic signed [DW-1:0] right_sum;
		logic last_flag;
	} fluct_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DW-2:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] direction = DIR_X;
	logic signed [DW-1:0] jump_0 = '0;
	logic signed [DW-1:0] jump_1 = '0;
	logic signed [DW-1:0] jump_2 = '0;
	logic signed [DW-1:0] jump_3 = '0;
	logic signed [DW-1:0] jump_4 = '0;
	logic signed [DW-1:0] jump_5 = '0;
	logic signed [DW-1:0] jump_6 = '0;
	logic signed [DW-1:0] jump_7 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [COMP_W-1:0] component;
	logic signed [DW-1:0] left_fluctuation;
	logic signed [DW-1:0] right_fluctuation;
	logic last;

	// Shadow copy of the register file, as seen by the predictor.
	longint set_light = longint'(SET_ONE);
	longint set_inv_light = longint'(SET_ONE);
	longint set_gamma = 0;
	longint set_chi = 0;

	interface_jump_t directed_rows [NUM_DIRECTED];
	logic signed [DW-1:0] known_left [NUM_KNOWN][NUM_COMP];
	logic signed [DW-1:0] known_right [NUM_KNOWN][NUM_COMP];
	fluct_result_t expected_fluct [$];

	bit quiet_mode = 1'b0;
	bit long_hold_req = 1'b0;
	int error_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int settings_loaded = 0;
	int long_holds = 0;
	int input_stall_cycles = 0;

	maxwell_fwave_riemann_split DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.direction        (direction),
		.jump_0           (jump_0),
		.jump_1           (jump_1),
		.jump_2           (jump_2),
		.jump_3           (jump_3),
		.jump_4           (jump_4),
		.jump_5           (jump_5),
		.jump_6           (jump_6),
		.jump_7           (jump_7),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.component        (component),
		.left_fluctuation (left_fluctuation),
		.right_fluctuation(right_fluctuation),
		.last             (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Fixed-point product: exact product, rounded half away from zero, then saturated.
	function automatic longint fx_mul(longint a, longint b);
		logic [63:0] mag_a;
		logic [63:0] mag_b;
		logic [63:0] prod;
		logic flip;
		mag_a = (a < 0) ? 64'(-a) : 64'(a);
		mag_b = (b < 0) ? 64'(-b) : 64'(b);
		flip = (a < 0) != (b < 0);
		prod = (mag_a * mag_b + (64'd1 << (FB - 1))) >> FB;
		if (!flip)
			return (prod > 64'(Q_MAX)) ? Q_MAX : longint'(prod);
		if (prod > 64'(Q_MAX))
			return Q_MIN;
		return -longint'(prod);
	endfunction

	function automatic longint fx_neg(longint x);
		return (x <= Q_MIN) ? Q_MAX : -x;
	endfunction

	// Halved sum, rounded toward minus infinity; cannot leave the range.
	function automatic longint fx_avg(longint x, longint y);
		return (x + y) >>> 1;
	endfunction

	// Works out the eight component results of one item and queues them.
	function automatic void predict_fluctuations(interface_jump_t it);
		longint j [NUM_COMP];
		longint lf [NUM_COMP];
		longint rt [NUM_COMP];
		int ax [6];
		int shift;
		longint cg, ck, ex, ey, ez, bx, by, bz, p, q;
		longint e0, e1, e2, b3, a1, a2, a3, a4, a5, a6, a7, a8;
		fluct_result_t r;
		if (it.known != NO_KNOWN) begin
			for (int m = 0; m < NUM_COMP; m++) begin
				lf[m] = longint'(known_left[it.known][m]);
				rt[m] = longint'(known_right[it.known][m]);
			end
		end else begin
			for (int m = 0; m < NUM_COMP; m++)
				j[m] = longint'(it.jump[m]);
			// Rotate E and B so that the sweep axis comes first; code three acts as x.
			shift = (it.dir == DIR_Y) ? 1 : (it.dir == DIR_Z) ? 2 : 0;
			for (int k = 0; k < 3; k++) begin
				ax[k] = (k + shift) % 3;
				ax[k + 3] = 3 + (k + shift) % 3;
			end
			ex = j[ax[0]]; ey = j[ax[1]]; ez = j[ax[2]];
			bx = j[ax[3]]; by = j[ax[4]]; bz = j[ax[5]];
			p = j[6]; q = j[7];

			cg = fx_mul(set_light, set_gamma);
			ck = fx_mul(set_light, set_chi);
			e0 = fx_mul(ex, set_inv_light);
			e1 = fx_mul(ey, set_inv_light);
			e2 = fx_mul(ez, set_inv_light);
			b3 = fx_mul(bx, set_light);
			a1 = fx_avg(e1, bz);
			a2 = fx_avg(fx_neg(e2), by);
			a3 = fx_avg(fx_neg(e1), bz);
			a4 = fx_avg(e2, by);
			a5 = fx_avg(b3, q);
			a6 = fx_avg(fx_neg(b3), q);
			a7 = fx_avg(e0, p);
			a8 = fx_avg(fx_neg(e0), p);

			// Right-going waves.
			rt[ax[1]] = fx_mul(set_light, fx_mul(set_light, a1));
			rt[ax[2]] = fx_neg(fx_mul(set_light, fx_mul(set_light, a2)));
			rt[ax[4]] = fx_mul(set_light, a2);
			rt[ax[5]] = fx_mul(set_light, a1);
			rt[ax[3]] = fx_mul(cg, fx_mul(a5, set_inv_light));
			rt[7] = fx_mul(cg, a5);
			rt[ax[0]] = fx_mul(ck, fx_mul(set_light, a7));
			rt[6] = fx_mul(ck, a7);

			// Left-going waves.
			lf[ax[1]] = fx_mul(set_light, fx_mul(set_light, a3));
			lf[ax[2]] = fx_neg(fx_mul(set_light, fx_mul(set_light, a4)));
			lf[ax[4]] = fx_neg(fx_mul(set_light, a4));
			lf[ax[5]] = fx_neg(fx_mul(set_light, a3));
			lf[ax[3]] = fx_mul(cg, fx_mul(a6, set_inv_light));
			lf[7] = fx_neg(fx_mul(cg, a6));
			lf[ax[0]] = fx_mul(ck, fx_mul(set_light, a8));
			lf[6] = fx_neg(fx_mul(ck, a8));
		end
		for (int m = 0; m < NUM_COMP; m++) begin
			r.comp = COMP_W'(m);
			r.left_sum = DW'(lf[m]);
			r.right_sum = DW'(rt[m]);
			r.last_flag = (COMP_W'(m) == LAST_COMP);
			expected_fluct.push_back(r);
		end
	endfunction

	// Jump values weighted toward the range ends, zero and small magnitudes.
	function automatic logic signed [DW-1:0] rand_jump();
		logic signed [DW-1:0] v;
		case ($urandom_range(0, 7))
			0: v = BOTTOM;
			1: v = TOP;
			2: v = '0;
			3: v = -1;
			4, 5: v = DW'($urandom_range(0, 32'h0008_0000)) - DW'(32'h0004_0000);
			default: v = DW'($urandom());
		endcase
		return v;
	endfunction

	function automatic logic [DW-2:0] rand_setting(bit nonzero);
		logic [DW-2:0] v;
		case ($urandom_range(0, 3))
			0: v = (DW-1)'($urandom());
			1: v = (DW-1)'($urandom_range(32'h0000_4000, 32'h0004_0000));
			2: v = (DW-1)'($urandom_range(0, 255));
			default: v = (DW-1)'($urandom_range(0, 32'h0100_0000));
		endcase
		if (nonzero && v == '0)
			v = SET_LSB;
		return v;
	endfunction

	function automatic interface_jump_t random_jump_row();
		interface_jump_t it;
		it.dir = 2'($urandom_range(0, 3));
		for (int m = 0; m < NUM_COMP; m++)
			it.jump[m] = rand_jump();
		it.known = NO_KNOWN;
		return it;
	endfunction

	// One register write; the caller lowers cfg_valid after the last one.
	task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [DW-2:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LIGHT_SPEED: set_light = longint'(value);
			CFG_INV_LIGHT: set_inv_light = longint'(value);
			CFG_MAG_CLEANING: set_gamma = longint'(value);
			CFG_ELEC_CLEANING: set_chi = longint'(value);
			default: ;
		endcase
	endtask

	task automatic load_settings(logic [DW-2:0] c, logic [DW-2:0] ic, logic [DW-2:0] g,
			logic [DW-2:0] x);
		write_setting(CFG_LIGHT_SPEED, c);
		write_setting(CFG_INV_LIGHT, ic);
		write_setting(CFG_MAG_CLEANING, g);
		write_setting(CFG_ELEC_CLEANING, x);
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	// Offers one item and returns at the edge where it is taken.
	task automatic send_jump(interface_jump_t it);
		in_valid <= 1'b1;
		direction <= it.dir;
		jump_0 <= it.jump[0];
		jump_1 <= it.jump[1];
		jump_2 <= it.jump[2];
		jump_3 <= it.jump[3];
		jump_4 <= it.jump[4];
		jump_5 <= it.jump[5];
		jump_6 <= it.jump[6];
		jump_7 <= it.jump[7];
		do @(posedge clk); while (in_stall);
		predict_fluctuations(it);
		items_sent++;
	endtask

	task automatic random_gap();
		if (!quiet_mode && !long_hold_req && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every queued result has been seen.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_fluct.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stall bursts, plus one long hold on request.
	initial begin : result_receiver
		int unsigned n;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				for (n = 0; n < LONG_HOLD; n++)
					@(posedge clk);
				out_stall <= 1'b0;
				long_hold_req = 1'b0;
				long_holds++;
			end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				n = $urandom_range(1, 5);
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Compare each accepted result transaction with the oldest expectation.
	always @(posedge clk) begin : result_check
		fluct_result_t want;
		if (in_valid && in_stall)
			input_stall_cycles++;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_fluct.size() == 0) begin
				error_count++;
				$display("%0t ns: result with nothing expected, component %0d", $time,
					component);
			end else begin
				want = expected_fluct.pop_front();
				results_checked++;
				if (component !== want.comp) begin
					error_count++;
					$display("%0t ns: component expected %0d got %0d", $time, want.comp,
						component);
				end
				if (left_fluctuation !== want.left_sum) begin
					error_count++;
					$display("%0t ns: component %0d left_fluctuation expected %h got %h",
						$time, want.comp, want.left_sum, left_fluctuation);
				end
				if (right_fluctuation !== want.right_sum) begin
					error_count++;
					$display("%0t ns: component %0d right_fluctuation expected %h got %h",
						$time, want.comp, want.right_sum, right_fluctuation);
				end
				if (last !== want.last_flag) begin
					error_count++;
					$display("%0t ns: component %0d last expected %b got %b", $time,
						want.comp, want.last_flag, last);
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d results still expected", expected_fluct.size());
		$display("[maxwell_fwave_riemann_split] ERROR");
		$finish;
	end

	initial begin : stimulus
		interface_jump_t row;
		int phase_items;

		// Hand-checked results under the reset settings (c = 1/c = 1.0, no cleaning).
		for (int i = 0; i < NUM_KNOWN; i++) begin
			for (int m = 0; m < NUM_COMP; m++) begin
				known_left[i][m] = '0;
				known_right[i][m] = '0;
			end
		end
		// An Ey jump of 2.0 along x splits into +-1.0 on Ey and Bz.
		known_left[KNOWN_EY_X][1] = -ONE;
		known_right[KNOWN_EY_X][1] = ONE;
		known_left[KNOWN_EY_X][5] = ONE;
		known_right[KNOWN_EY_X][5] = ONE;
		// Along z the same jump is the Ez wave, landing on components one and three.
		known_left[KNOWN_EZ_Z][1] = -ONE;
		known_right[KNOWN_EZ_Z][1] = ONE;
		known_left[KNOWN_EZ_Z][3] = -ONE;
		known_right[KNOWN_EZ_Z][3] = -ONE;

		directed_rows = '{
			'{DIR_X, '{0, 0, 0, 0, 0, 0, 0, 0}, KNOWN_ZERO},
			'{DIR_X, '{0, TWO, 0, 0, 0, 0, 0, 0}, KNOWN_EY_X},
			'{DIR_Y, '{0, TWO, 0, 0, 0, 0, 0, 0}, KNOWN_ZERO},
			'{DIR_Z, '{0, TWO, 0, 0, 0, 0, 0, 0}, KNOWN_EZ_Z},
			'{DIR_SPARE, '{0, TWO, 0, 0, 0, 0, 0, 0}, KNOWN_EY_X},
			'{DIR_X, '{0, 0, 0, 0, 0, 0, TWO, 0}, KNOWN_ZERO},
			'{DIR_X, '{0, 0, 0, 0, 0, 0, 0, TWO}, KNOWN_ZERO},
			'{DIR_X, '{0, 0, 0, TWO, 0, 0, 0, 0}, KNOWN_ZERO},
			'{DIR_X, '{TOP, TOP, TOP, TOP, TOP, TOP, TOP, TOP}, NO_KNOWN},
			'{DIR_X, '{BOTTOM, BOTTOM, BOTTOM, BOTTOM, BOTTOM, BOTTOM, BOTTOM, BOTTOM},
				NO_KNOWN},
			'{DIR_Y, '{BOTTOM, TOP, BOTTOM, TOP, BOTTOM, TOP, BOTTOM, TOP}, NO_KNOWN},
			'{DIR_Z, '{TOP, BOTTOM, TOP, BOTTOM, TOP, BOTTOM, TOP, BOTTOM}, NO_KNOWN},
			'{DIR_X, '{-1, -1, -1, -1, -1, -1, -1, -1}, NO_KNOWN},
			'{DIR_Y, '{1, 1, 1, 1, 1, 1, 1, 1}, NO_KNOWN},
			'{DIR_Z, '{ONE, -ONE, 3, -3, 32'sh0001_8000, -32'sh0002_8000, ONE, -ONE},
				NO_KNOWN},
			'{DIR_SPARE, '{TOP, -ONE, 7, BOTTOM, TWO, -5, BOTTOM, TOP}, NO_KNOWN},
			'{DIR_X, '{0, 1, 0, 0, 0, -3, 0, 0}, NO_KNOWN}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset register values.
		for (int r = 0; r < NUM_DIRECTED; r++) begin
			send_jump(directed_rows[r]);
			random_gap();
		end
		drain_results();

		// Random phases, one register setting each.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: load_settings(SET_ONE, SET_ONE, SET_ONE >> 1, SET_ONE << 1);
				1: load_settings(SET_MAX, SET_MAX, SET_MAX, SET_MAX);
				// Tiny speeds: the cleaning wave speeds round to zero.
				2: load_settings(SET_LSB, SET_LSB, SET_LSB, SET_LSB);
				3: load_settings(SET_ONE << 1, SET_ONE >> 1, SET_ONE, '0);
				default: load_settings(rand_setting(1'b1), rand_setting(1'b1),
					rand_setting(1'b0), rand_setting(1'b0));
			endcase
			quiet_mode = (phase == NUM_PHASES - 1);
			phase_items = (phase == 0) ? 30 : 20;
			for (int i = 0; i < phase_items; i++) begin
				row = random_jump_row();
				// Hold the result side off so that the pipeline backs up.
				if (phase == 0 && i == 2)
					long_hold_req = 1'b1;
				send_jump(row);
				if (phase == 3 && i == 10)
					drain_results();
				else
					random_gap();
			end
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d items over %0d register settings plus reset values,",
			items_sent, settings_loaded);
		$display("%0d results checked, %0d long holds, %0d cycles of input stall",
			results_checked, long_holds, input_stall_cycles);
		if (error_count == 0)
			$display("[maxwell_fwave_riemann_split] OK");
		else
			$display("[maxwell_fwave_riemann_split] ERROR");
		$finish;
	end

endmodule

@@ maxwell_fwave_riemann_split.f @@
rtl/core/mwfr_pkg.sv
rtl/core/mwfr_fmul.sv
rtl/core/maxwell_fwave_riemann_split.sv
rtl/core/mwfr_checker.sv
tb/maxwell_fwave_riemann_split_tb.sv
